// File: hw/rtl/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// Shared types, codes and the CRC-32 byte update for the challenge relay.
// ----------------------------------------------------------------------------
package acr_pkg;

  localparam int LEN_W = 7;
  localparam int OFF_W = 6;
  localparam int SLOT_W = 5;

  localparam logic [1:0] RT_HOST_BYTE = 2'd0;
  localparam logic [1:0] RT_HOST_READ = 2'd1;
  localparam logic [1:0] RT_CTRL_BYTE = 2'd2;

  localparam logic [1:0] DEST_HOST = 2'd0;
  localparam logic [1:0] DEST_CTRL_DATA = 2'd1;
  localparam logic [1:0] DEST_CTRL_REQ = 2'd2;
  localparam logic [1:0] DEST_NOTICE = 2'd3;

  localparam logic [2:0] NOTE_NONE = 3'd0;
  localparam logic [2:0] NOTE_BAD_HOST_WR = 3'd1;
  localparam logic [2:0] NOTE_BAD_HOST_RD = 3'd2;
  localparam logic [2:0] NOTE_BAD_CTRL = 3'd3;
  localparam logic [2:0] NOTE_RANGE = 3'd4;

  localparam logic [7:0] ID_STATUS = 8'hf2;
  localparam logic [7:0] ID_RESPONSE = 8'hf1;
  localparam logic [7:0] CHAL_PREFIX = 8'h53;
  localparam logic [7:0] CHAL_START = 8'h04;
  localparam logic [7:0] FLAG_BUSY = 8'h10;
  localparam logic [7:0] FLAG_DONE = 8'h00;

  typedef enum logic [1:0] {
    M_IDLE, M_WAITING, M_COLLECTING, M_READY
  } mode_t;

  typedef enum logic [2:0] {
    B_NONE, B_NOTICE, B_FWD, B_STATUS, B_REPLAY, B_REQ, B_WHDR, B_WDATA
  } burst_t;

  typedef enum logic [1:0] {
    S_IDLE, S_EXEC, S_FETCH, S_PUT
  } state_t;

  typedef struct packed {
    logic             capture;
    logic             exec;
    logic             fetch;
    logic             put;
    logic             last;
    logic [LEN_W-1:0] pos;
  } acr_cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             is_write;
    logic             out_free;
  } acr_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// File: hw/rtl/acr_in_if.sv
// ----------------------------------------------------------------------------
// acr_in_if
// Input channel: host and controller events.
// ----------------------------------------------------------------------------
interface acr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] report_id;
  logic [7:0] data_byte;
  logic [5:0] byte_index;
  logic       last_byte;

  modport source (output valid, req_type, report_id, data_byte, byte_index, last_byte,
                  input ready);
  modport sink (input valid, req_type, report_id, data_byte, byte_index, last_byte,
                output ready);
endinterface

// File: hw/rtl/acr_out_if.sv
// ----------------------------------------------------------------------------
// acr_out_if
// Result channel: host replies, controller traffic and notices.
// ----------------------------------------------------------------------------
interface acr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] dest;
  logic [7:0] out_byte;
  logic [7:0] request_id;
  logic [6:0] request_length;
  logic [2:0] notice_code;
  logic       last;

  modport source (output valid, dest, out_byte, request_id, request_length, notice_code,
                  last, input ready);
  modport sink (input valid, dest, out_byte, request_id, request_length, notice_code,
                last, output ready);
endinterface

// File: hw/rtl/auth_challenge_relay_core.sv
// ----------------------------------------------------------------------------
// auth_challenge_relay_core
// Challenge-response relay between a host and a controller.
// ----------------------------------------------------------------------------
// One transaction is taken at a time: it is captured, then decoded. Each result
// is then fetched and loaded into the output register, and each response store
// write is made in the fetch step, all through the single-port response store.
// The store is not cleared; replaying an uncollected slot returns stale data.
module auth_challenge_relay_core
  import acr_pkg::*;
#(
  parameter int RESPONSE_COUNT = 19,
  parameter int RESPONSE_BYTES = 64,
  parameter int STATUS_BYTES   = 16
) (
  input logic     clk,
  input logic     rst_n,
  acr_in_if.sink  in_chan,
  acr_out_if.source out_chan
);

  acr_cmd_t  cmd;
  acr_stat_t stat;
  logic      rdy;

  assign in_chan.ready = rdy;

  acr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (rdy),
    .stat     (stat),
    .cmd      (cmd)
  );

  acr_dp #(
    .RESPONSE_COUNT (RESPONSE_COUNT),
    .RESPONSE_BYTES (RESPONSE_BYTES),
    .STATUS_BYTES   (STATUS_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_req_type        (in_chan.req_type),
    .in_report_id       (in_chan.report_id),
    .in_data_byte       (in_chan.data_byte),
    .in_byte_index      (in_chan.byte_index),
    .in_last_byte       (in_chan.last_byte),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_dest           (out_chan.dest),
    .out_byte           (out_chan.out_byte),
    .out_request_id     (out_chan.request_id),
    .out_request_length (out_chan.request_length),
    .out_notice_code    (out_chan.notice_code),
    .out_last           (out_chan.last)
  );

endmodule

// File: hw/rtl/acr_ctrl.sv
// ----------------------------------------------------------------------------
// acr_ctrl
// Sequencer: accepts a transaction, runs it, then steps its burst.
// ----------------------------------------------------------------------------
module acr_ctrl
  import acr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  acr_stat_t stat,
  output acr_cmd_t  cmd
);

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             at_end;

  assign at_end = (pos_r == stat.len - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_FETCH;
        pos_nxt   = '0;
      end
      S_FETCH: begin
        if (stat.len == '0) begin
          state_nxt = S_IDLE;
        end else if (stat.is_write) begin
          if (at_end) state_nxt = S_IDLE;
          else pos_nxt = pos_r + LEN_W'(1);
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (stat.out_free) begin
          if (at_end) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FETCH;
            pos_nxt   = pos_r + LEN_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == S_IDLE);
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.exec    = (state_r == S_EXEC);
    cmd.fetch   = (state_r == S_FETCH) && (stat.len != '0);
    cmd.put     = (state_r == S_PUT) && stat.out_free;
    cmd.last    = at_end;
    cmd.pos     = pos_r;
  end

endmodule

// File: hw/rtl/acr_dp.sv
// ----------------------------------------------------------------------------
// acr_dp
// Datapath: relay state, response store, CRC units and the result register.
// ----------------------------------------------------------------------------
module acr_dp
  import acr_pkg::*;
#(
  parameter int RESPONSE_COUNT = 19,
  parameter int RESPONSE_BYTES = 64,
  parameter int STATUS_BYTES   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  acr_cmd_t   cmd,
  output acr_stat_t  stat,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_report_id,
  input  logic [7:0] in_data_byte,
  input  logic [5:0] in_byte_index,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_dest,
  output logic [7:0] out_byte,
  output logic [7:0] out_request_id,
  output logic [6:0] out_request_length,
  output logic [2:0] out_notice_code,
  output logic       out_last
);

  localparam int DEPTH = RESPONSE_COUNT * RESPONSE_BYTES;
  localparam int AW = $clog2(DEPTH);
  localparam logic [7:0] RC8 = 8'(RESPONSE_COUNT);
  localparam logic [6:0] RB_LAST = 7'(RESPONSE_BYTES - 4);
  localparam logic [LEN_W-1:0] SB_DATA = LEN_W'(STATUS_BYTES - 4);

  // transaction capture
  logic [1:0] rt_r;
  logic [7:0] id_r, d_r;
  logic [5:0] idx_r;
  logic       lb_r;

  // relay state
  mode_t        mode_r, mode_nxt;
  logic [7:0]   seq_r, seq_nxt;
  logic [SLOT_W-1:0] replay_r, replay_nxt;
  logic [31:0]  crc_r, crc_nxt;
  logic [15:0]  held_r, held_nxt;
  logic [7:0]   kind_r, kind_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // burst plan
  burst_t            bk_r, bk_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              pre_r, pre_nxt;
  logic [2:0]        code_r, code_nxt;
  logic [7:0]        flag_r, flag_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [OFF_W-1:0]  wr_off_r, wr_off_nxt;
  logic [31:0]       fin_r, fin_nxt;
  logic [31:0]       scrc_r;

  // store
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] addr;
  logic [7:0]    wr_data;

  // result register
  logic       ov_r;
  logic [1:0] dest_r;
  logic [7:0] byte_r, rid_r;
  logic [6:0] rlen_r;
  logic [2:0] ncode_r;
  logic       last_r;

  logic [LEN_W-1:0] e;
  logic [1:0]  el_dest;
  logic [7:0]  el_byte, el_rid;
  logic [6:0]  el_rlen;
  logic [2:0]  el_code;
  logic        el_crc_en;
  logic [31:0] crc_tmp;
  logic [7:0]  fwd_total;

  assign stat.len      = len_r;
  assign stat.is_write = (bk_r == B_WHDR) || (bk_r == B_WDATA);
  assign stat.out_free = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rt_r  <= in_req_type;
      id_r  <= in_report_id;
      d_r   <= in_data_byte;
      idx_r <= in_byte_index;
      lb_r  <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      seq_r    <= '0;
      replay_r <= '0;
      crc_r    <= '1;
      held_r   <= '0;
      kind_r   <= '0;
      slot_r   <= '0;
      bk_r     <= B_NONE;
      len_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      seq_r    <= seq_nxt;
      replay_r <= replay_nxt;
      crc_r    <= crc_nxt;
      held_r   <= held_nxt;
      kind_r   <= kind_nxt;
      slot_r   <= slot_nxt;
      bk_r     <= bk_nxt;
      len_r    <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pre_r     <= pre_nxt;
    code_r    <= code_nxt;
    flag_r    <= flag_nxt;
    rd_slot_r <= rd_slot_nxt;
    wr_off_r  <= wr_off_nxt;
    fin_r     <= fin_nxt;
  end

  // transaction decode
  always_comb begin
    mode_nxt    = mode_r;
    seq_nxt     = seq_r;
    replay_nxt  = replay_r;
    crc_nxt     = crc_r;
    held_nxt    = held_r;
    kind_nxt    = kind_r;
    slot_nxt    = slot_r;
    bk_nxt      = bk_r;
    len_nxt     = len_r;
    pre_nxt     = pre_r;
    code_nxt    = code_r;
    flag_nxt    = flag_r;
    rd_slot_nxt = rd_slot_r;
    wr_off_nxt  = wr_off_r;
    fin_nxt     = fin_r;
    crc_tmp     = crc_byte(crc_r, d_r);
    fwd_total   = '0;
    if (cmd.exec) begin
      bk_nxt   = B_NONE;
      len_nxt  = '0;
      pre_nxt  = 1'b0;
      code_nxt = NOTE_NONE;
      case (rt_r)
        RT_HOST_BYTE: begin
          if (mode_r != M_IDLE) begin
            if (lb_r) begin
              bk_nxt   = B_NOTICE;
              len_nxt  = LEN_W'(1);
              code_nxt = NOTE_BAD_HOST_WR;
            end
          end else begin
            if (idx_r == 6'd0) begin
              held_nxt = '0;
              pre_nxt  = 1'b1;
            end else if (idx_r == 6'd1) begin
              held_nxt = {held_r[15:8], d_r};
            end else if (idx_r == 6'd2) begin
              held_nxt = {d_r, held_r[7:0]};
            end
            fwd_total = {7'd0, pre_nxt} + 8'd1;
            if (lb_r) begin
              if (7'(idx_r) + 7'd1 < 7'(RESPONSE_BYTES)) begin
                fwd_total = fwd_total + 8'(RESPONSE_BYTES - 1) - {2'd0, idx_r};
              end
              if (held_nxt[15:8] == CHAL_START) begin
                seq_nxt  = held_nxt[7:0];
                mode_nxt = M_WAITING;
              end
            end
            bk_nxt  = B_FWD;
            len_nxt = (fwd_total > 8'd64) ? LEN_W'(64) : fwd_total[LEN_W-1:0];
          end
        end
        RT_HOST_READ: begin
          if (id_r == ID_STATUS) begin
            if (mode_r == M_IDLE) begin
              bk_nxt   = B_NOTICE;
              len_nxt  = LEN_W'(1);
              code_nxt = NOTE_BAD_HOST_RD;
            end else begin
              bk_nxt   = B_STATUS;
              flag_nxt = (mode_r == M_READY) ? FLAG_DONE : FLAG_BUSY;
              pre_nxt  = (mode_r == M_WAITING);
              len_nxt  = LEN_W'(STATUS_BYTES) + LEN_W'(pre_nxt);
            end
          end else if (id_r == ID_RESPONSE) begin
            if (replay_r >= SLOT_W'(RESPONSE_COUNT)) begin
              bk_nxt   = B_NOTICE;
              len_nxt  = LEN_W'(1);
              code_nxt = NOTE_RANGE;
            end else begin
              bk_nxt      = B_REPLAY;
              len_nxt     = LEN_W'(RESPONSE_BYTES);
              rd_slot_nxt = replay_r;
              replay_nxt  = replay_r + SLOT_W'(1);
              if (replay_nxt == SLOT_W'(RESPONSE_COUNT)) mode_nxt = M_IDLE;
            end
          end else begin
            bk_nxt   = B_NOTICE;
            len_nxt  = LEN_W'(1);
            code_nxt = NOTE_BAD_HOST_RD;
          end
        end
        RT_CTRL_BYTE: begin
          if (idx_r == 6'd0) begin
            kind_nxt = '0;
            slot_nxt = '0;
            held_nxt = '0;
            crc_nxt  = '1;
          end else if (idx_r == 6'd1) begin
            kind_nxt = '0;
            if (d_r == ID_RESPONSE && mode_r == M_COLLECTING) begin
              kind_nxt = d_r;
              crc_nxt  = crc_byte(32'hffffffff, d_r);
            end else if (d_r == ID_STATUS && mode_r == M_WAITING) begin
              kind_nxt = d_r;
            end else begin
              bk_nxt   = B_NOTICE;
              len_nxt  = LEN_W'(1);
              code_nxt = NOTE_BAD_CTRL;
            end
          end else if (idx_r == 6'd2) begin
            held_nxt = {8'd0, d_r};
            if (kind_r == ID_RESPONSE) crc_nxt = crc_tmp;
          end else if (idx_r == 6'd3) begin
            if (kind_r == ID_STATUS) begin
              kind_nxt = '0;
              if (!d_r[4]) begin
                mode_nxt = M_COLLECTING;
                bk_nxt   = B_REQ;
                len_nxt  = LEN_W'(RESPONSE_COUNT);
              end
            end else if (kind_r == ID_RESPONSE) begin
              if (d_r >= RC8) begin
                kind_nxt = '0;
                bk_nxt   = B_NOTICE;
                len_nxt  = LEN_W'(1);
                code_nxt = NOTE_RANGE;
              end else begin
                slot_nxt   = d_r[SLOT_W-1:0];
                crc_nxt    = crc_tmp;
                bk_nxt     = B_WHDR;
                len_nxt    = LEN_W'(3);
                wr_off_nxt = '0;
              end
            end
          end else if (kind_r == ID_RESPONSE && 7'(idx_r) <= RB_LAST) begin
            crc_nxt    = crc_tmp;
            bk_nxt     = B_WDATA;
            len_nxt    = LEN_W'(1);
            wr_off_nxt = idx_r - 6'd1;
            if (7'(idx_r) == RB_LAST) begin
              fin_nxt  = ~crc_tmp;
              len_nxt  = LEN_W'(5);
              kind_nxt = '0;
              if (slot_r == SLOT_W'(RESPONSE_COUNT - 1)) begin
                replay_nxt = '0;
                mode_nxt   = M_READY;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // store port
  always_comb begin
    if (stat.is_write) begin
      addr = AW'(slot_r) * AW'(RESPONSE_BYTES) + AW'(wr_off_r) + AW'(cmd.pos);
    end else begin
      addr = AW'(rd_slot_r) * AW'(RESPONSE_BYTES) + AW'(cmd.pos);
    end
    wr_data = d_r;
    if (bk_r == B_WHDR) begin
      case (cmd.pos[1:0])
        2'd0:    wr_data = ID_RESPONSE;
        2'd1:    wr_data = held_r[7:0];
        default: wr_data = d_r;
      endcase
    end else if (cmd.pos != '0) begin
      wr_data = 8'(fin_r >> (8 * (cmd.pos[2:0] - 3'd1)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      if (stat.is_write) mem[addr] <= wr_data;
      else rd_data_r <= mem[addr];
    end
  end

  // element of the current burst
  always_comb begin
    e         = cmd.pos - LEN_W'(pre_r);
    el_dest   = DEST_HOST;
    el_byte   = '0;
    el_rid    = '0;
    el_rlen   = '0;
    el_code   = NOTE_NONE;
    el_crc_en = 1'b0;
    case (bk_r)
      B_NOTICE: begin
        el_dest = DEST_NOTICE;
        el_code = code_r;
      end
      B_FWD: begin
        el_dest = DEST_CTRL_DATA;
        if (pre_r && cmd.pos == '0) el_byte = CHAL_PREFIX;
        else if (e == '0) el_byte = d_r;
      end
      B_STATUS: begin
        if (pre_r && cmd.pos == '0) begin
          el_dest = DEST_CTRL_REQ;
          el_rid  = ID_STATUS;
          el_rlen = 7'(STATUS_BYTES);
        end else if (e < SB_DATA) begin
          el_crc_en = 1'b1;
          if (e == LEN_W'(0)) el_byte = ID_STATUS;
          else if (e == LEN_W'(1)) el_byte = seq_r;
          else if (e == LEN_W'(2)) el_byte = flag_r;
        end else begin
          el_byte = 8'((~scrc_r) >> {e[1:0] - SB_DATA[1:0], 3'b000});
        end
      end
      B_REPLAY: el_byte = rd_data_r;
      B_REQ: begin
        el_dest = DEST_CTRL_REQ;
        el_rid  = ID_RESPONSE;
        el_rlen = 7'(RESPONSE_BYTES);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) scrc_r <= '1;
    else if (cmd.put && el_crc_en) scrc_r <= crc_byte(scrc_r, el_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.put) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      dest_r  <= el_dest;
      byte_r  <= el_byte;
      rid_r   <= el_rid;
      rlen_r  <= el_rlen;
      ncode_r <= el_code;
      last_r  <= cmd.last;
    end
  end

  assign out_valid          = ov_r;
  assign out_dest           = dest_r;
  assign out_byte           = byte_r;
  assign out_request_id     = rid_r;
  assign out_request_length = rlen_r;
  assign out_notice_code    = ncode_r;
  assign out_last           = last_r;

endmodule

// File: dv/acr_relay_checker.sv
// ----------------------------------------------------------------------------
// acr_relay_checker
// Watches both channels of the challenge relay. On every accepted input
// transaction it predicts the results from its own copy of the relay state,
// then compares each accepted result field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module acr_relay_checker
  import acr_pkg::*;
#(
  parameter int RESPONSE_COUNT = 19,
  parameter int RESPONSE_BYTES = 64,
  parameter int STATUS_BYTES   = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  acr_in_if     in_mon,
  acr_out_if    out_mon,
  output int    mismatch_count,
  output int    outstanding,
  output mode_t pred_mode
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PER_TXN = 64;

  typedef struct packed {
    logic [1:0] dest;
    logic [7:0] data;
    logic [7:0] req_id;
    logic [6:0] req_len;
    logic [2:0] code;
    logic       last;
  } relay_result_t;

  relay_result_t expected_results[$];
  relay_result_t txn_results[$];

  logic [7:0]  seq_num;
  logic [4:0]  replay_idx;
  logic [7:0]  resp_mem [RESPONSE_COUNT*RESPONSE_BYTES];
  logic [31:0] crc_acc;
  logic [15:0] held;
  logic [7:0]  in_kind;
  logic [4:0]  in_slot;

  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) r = (r >> 1) ^ 32'hEDB88320;
      else r = r >> 1;
    end
    return r;
  endfunction

  task automatic add_result(input logic [1:0] dest, input logic [7:0] data,
                            input logic [7:0] rid, input logic [6:0] rlen,
                            input logic [2:0] code);
    relay_result_t r;
    r = '{dest: dest, data: data, req_id: rid, req_len: rlen, code: code, last: 1'b0};
    if (txn_results.size() < MAX_PER_TXN) txn_results.push_back(r);
  endtask

  task automatic add_status_frame(input logic [7:0] flag);
    logic [7:0]  frame [STATUS_BYTES];
    logic [31:0] c;
    foreach (frame[i]) frame[i] = 8'h00;
    frame[0] = ID_STATUS;
    frame[1] = seq_num;
    frame[2] = flag;
    c = 32'hffffffff;
    for (int i = 0; i < STATUS_BYTES - 4; i++) c = crc32_update(c, frame[i]);
    c = ~c;
    for (int i = 0; i < 4; i++) frame[STATUS_BYTES-4+i] = c[8*i +: 8];
    for (int i = 0; i < STATUS_BYTES; i++) add_result(DEST_HOST, frame[i], 8'h00, 7'd0, NOTE_NONE);
  endtask

  task automatic predict_challenge(input logic [7:0] d, input logic [5:0] idx, input logic lb);
    if (pred_mode != M_IDLE) begin
      if (lb) add_result(DEST_NOTICE, 8'h00, 8'h00, 7'd0, NOTE_BAD_HOST_WR);
      return;
    end
    if (idx == 0) begin
      held = 16'h0000;
      add_result(DEST_CTRL_DATA, CHAL_PREFIX, 8'h00, 7'd0, NOTE_NONE);
    end else if (idx == 1) begin
      held[7:0] = d;
    end else if (idx == 2) begin
      held[15:8] = d;
    end
    add_result(DEST_CTRL_DATA, d, 8'h00, 7'd0, NOTE_NONE);
    if (lb) begin
      for (int k = int'(idx) + 1; k < RESPONSE_BYTES; k++)
        add_result(DEST_CTRL_DATA, 8'h00, 8'h00, 7'd0, NOTE_NONE);
      if (held[15:8] == CHAL_START) begin
        seq_num = held[7:0];
        pred_mode = M_WAITING;
      end
    end
  endtask

  task automatic predict_host_read(input logic [7:0] id);
    int base;
    if (id == ID_STATUS) begin
      if (pred_mode == M_IDLE) begin
        add_result(DEST_NOTICE, 8'h00, 8'h00, 7'd0, NOTE_BAD_HOST_RD);
      end else if (pred_mode == M_READY) begin
        add_status_frame(FLAG_DONE);
      end else begin
        if (pred_mode == M_WAITING)
          add_result(DEST_CTRL_REQ, 8'h00, ID_STATUS, 7'(STATUS_BYTES), NOTE_NONE);
        add_status_frame(FLAG_BUSY);
      end
    end else if (id == ID_RESPONSE) begin
      if (replay_idx >= RESPONSE_COUNT) begin
        add_result(DEST_NOTICE, 8'h00, 8'h00, 7'd0, NOTE_RANGE);
        return;
      end
      base = int'(replay_idx) * RESPONSE_BYTES;
      for (int i = 0; i < RESPONSE_BYTES; i++)
        add_result(DEST_HOST, resp_mem[base+i], 8'h00, 7'd0, NOTE_NONE);
      replay_idx = replay_idx + 5'd1;
      if (replay_idx == RESPONSE_COUNT) pred_mode = M_IDLE;
    end else begin
      add_result(DEST_NOTICE, 8'h00, 8'h00, 7'd0, NOTE_BAD_HOST_RD);
    end
  endtask

  task automatic predict_ctrl_byte(input logic [7:0] d, input logic [5:0] idx);
    int base;
    logic [31:0] c;
    if (idx == 0) begin
      in_kind = 8'h00;
      in_slot = 5'd0;
      held = 16'h0000;
      crc_acc = 32'hffffffff;
    end else if (idx == 1) begin
      in_kind = 8'h00;
      if (d == ID_RESPONSE && pred_mode == M_COLLECTING) begin
        in_kind = d;
        crc_acc = crc32_update(32'hffffffff, d);
      end else if (d == ID_STATUS && pred_mode == M_WAITING) begin
        in_kind = d;
      end else begin
        add_result(DEST_NOTICE, 8'h00, 8'h00, 7'd0, NOTE_BAD_CTRL);
      end
    end else if (idx == 2) begin
      held = {8'h00, d};
      if (in_kind == ID_RESPONSE) crc_acc = crc32_update(crc_acc, d);
    end else if (idx == 3) begin
      if (in_kind == ID_STATUS) begin
        in_kind = 8'h00;
        if (!d[4]) begin
          pred_mode = M_COLLECTING;
          for (int k = 0; k < RESPONSE_COUNT; k++)
            add_result(DEST_CTRL_REQ, 8'h00, ID_RESPONSE, 7'(RESPONSE_BYTES), NOTE_NONE);
        end
      end else if (in_kind == ID_RESPONSE) begin
        if (d >= RESPONSE_COUNT) begin
          in_kind = 8'h00;
          add_result(DEST_NOTICE, 8'h00, 8'h00, 7'd0, NOTE_RANGE);
        end else begin
          in_slot = d[4:0];
          base = int'(d) * RESPONSE_BYTES;
          resp_mem[base]   = ID_RESPONSE;
          resp_mem[base+1] = held[7:0];
          resp_mem[base+2] = d;
          crc_acc = crc32_update(crc_acc, d);
        end
      end
    end else if (in_kind == ID_RESPONSE && idx <= RESPONSE_BYTES - 4) begin
      base = int'(in_slot) * RESPONSE_BYTES;
      resp_mem[base+int'(idx)-1] = d;
      crc_acc = crc32_update(crc_acc, d);
      if (idx == RESPONSE_BYTES - 4) begin
        c = ~crc_acc;
        for (int k = 0; k < 4; k++) resp_mem[base+RESPONSE_BYTES-4+k] = c[8*k +: 8];
        in_kind = 8'h00;
        if (in_slot == RESPONSE_COUNT - 1) begin
          replay_idx = 5'd0;
          pred_mode = M_READY;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input relay_result_t exp_r,
                                 input relay_result_t act_r);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] MISMATCH %s: expected dest=%0d byte=%02h id=%02h len=%0d code=%0d last=%0d, actual dest=%0d byte=%02h id=%02h len=%0d code=%0d last=%0d",
               $time, what, exp_r.dest, exp_r.data, exp_r.req_id, exp_r.req_len, exp_r.code,
               exp_r.last, act_r.dest, act_r.data, act_r.req_id, act_r.req_len, act_r.code,
               act_r.last);
  endtask

  always @(posedge clk) begin
    relay_result_t act_r;
    relay_result_t exp_r;
    if (!rst_n) begin
      pred_mode = M_IDLE;
      seq_num = 8'h00;
      replay_idx = 5'd0;
      crc_acc = 32'hffffffff;
      held = 16'h0000;
      in_kind = 8'h00;
      in_slot = 5'd0;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        txn_results.delete();
        case (in_mon.req_type)
          RT_HOST_BYTE: predict_challenge(in_mon.data_byte, in_mon.byte_index, in_mon.last_byte);
          RT_HOST_READ: predict_host_read(in_mon.report_id);
          RT_CTRL_BYTE: predict_ctrl_byte(in_mon.data_byte, in_mon.byte_index);
          default: ;
        endcase
        if (txn_results.size() > 0) txn_results[txn_results.size()-1].last = 1'b1;
        foreach (txn_results[i]) expected_results.push_back(txn_results[i]);
      end
      if (out_mon.valid && out_mon.ready) begin
        act_r = '{dest: out_mon.dest, data: out_mon.out_byte, req_id: out_mon.request_id,
                  req_len: out_mon.request_length, code: out_mon.notice_code,
                  last: out_mon.last};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, act_r);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== act_r) report_mismatch("result fields", exp_r, act_r);
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// File: dv/tb_auth_challenge_relay_core.sv
// ----------------------------------------------------------------------------
// tb_auth_challenge_relay_core
// Stimulus and verdict for the challenge relay. Directed corner transactions
// are followed by three rounds (challenge, status exchange, response
// collection, replay of collected slots) with random content, broken reports
// and random noise, each round under a different backpressure profile.
// ----------------------------------------------------------------------------
module tb_auth_challenge_relay_core;
  import acr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESPONSE_COUNT = 19;
  localparam int RESPONSE_BYTES = 64;
  localparam int STATUS_BYTES   = 16;
  localparam int WATCHDOG_LIMIT = 5000;

  logic  clk;
  logic  rst_n;
  int    mismatch_count;
  int    outstanding;
  mode_t pred_mode;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    txn_count;
  int    replay_count;
  int    quiet_cycles = 0;
  int    replay_ptr;
  logic [RESPONSE_COUNT-1:0] slot_done;

  acr_in_if  in_chan ();
  acr_out_if out_chan ();

  auth_challenge_relay_core #(
    .RESPONSE_COUNT(RESPONSE_COUNT),
    .RESPONSE_BYTES(RESPONSE_BYTES),
    .STATUS_BYTES  (STATUS_BYTES)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  acr_relay_checker #(
    .RESPONSE_COUNT(RESPONSE_COUNT),
    .RESPONSE_BYTES(RESPONSE_BYTES),
    .STATUS_BYTES  (STATUS_BYTES)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding),
    .pred_mode     (pred_mode)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_chan.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // a response read is only issued when the slot it replays is fully written
  function automatic bit replay_ok();
    return (replay_ptr < RESPONSE_COUNT) && slot_done[replay_ptr];
  endfunction

  task automatic send_item(input logic [1:0] rt, input logic [7:0] id, input logic [7:0] d,
                           input logic [5:0] idx, input logic lb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.req_type   <= rt;
    in_chan.report_id  <= id;
    in_chan.data_byte  <= d;
    in_chan.byte_index <= idx;
    in_chan.last_byte  <= lb;
    do @(posedge clk); while (!in_chan.ready);
    txn_count++;
    if (rt == RT_HOST_READ && id == ID_RESPONSE) begin
      replay_count++;
      if (replay_ptr < RESPONSE_COUNT) replay_ptr++;
    end
    @(negedge clk);
  endtask

  task automatic send_noise();
    logic [7:0] id;
    id = 8'($urandom);
    if (id == ID_RESPONSE && !replay_ok()) id = ID_STATUS;
    send_item(2'($urandom_range(3)), id, 8'($urandom), 6'($urandom_range(63)),
              1'($urandom_range(1)));
  endtask

  task automatic send_read(input logic [7:0] id);
    send_item(RT_HOST_READ, id, 8'($urandom), 6'($urandom_range(63)), 1'($urandom_range(1)));
  endtask

  task automatic send_ctrl_status(input bit busy);
    logic [7:0] flags;
    flags = 8'($urandom);
    flags[4] = busy;
    for (int i = 0; i < 8; i++)
      send_item(RT_CTRL_BYTE, 8'($urandom),
                (i == 1) ? ID_STATUS : (i == 3) ? flags : 8'($urandom), 6'(i), i == 7);
  endtask

  task automatic send_response(input logic [7:0] slot, input int last_idx);
    bit collecting;
    collecting = (pred_mode == M_COLLECTING);
    for (int i = 0; i <= last_idx; i++)
      send_item(RT_CTRL_BYTE, 8'($urandom),
                (i == 1) ? ID_RESPONSE : (i == 3) ? slot : 8'($urandom), 6'(i), i == last_idx);
    if (collecting && slot < RESPONSE_COUNT && last_idx >= RESPONSE_BYTES - 4)
      slot_done[slot[4:0]] = 1'b1;
  endtask

  task automatic run_round();
    int         len;
    logic [7:0] seq;
    if (pred_mode == M_IDLE) begin
      seq = 8'($urandom);
      len = int'($urandom_range(3, 8));
      for (int i = 0; i < len; i++)
        send_item(RT_HOST_BYTE, 8'($urandom),
                  (i == 1) ? seq : (i == 2) ? CHAL_START : 8'($urandom), 6'(i), i == len - 1);
    end
    if (pred_mode == M_WAITING) begin
      send_read(ID_STATUS);
      send_ctrl_status(1'b1);
      send_ctrl_status(1'b0);
    end
    if (pred_mode == M_COLLECTING) begin
      send_read(ID_STATUS);
      if ($urandom_range(1) == 0) send_response(8'($urandom_range(255, RESPONSE_COUNT)), 7);
      if (!slot_done[0]) send_response(8'd0, RESPONSE_BYTES - 4 + int'($urandom_range(3)));
      else send_response(8'($urandom_range(RESPONSE_COUNT - 1)), int'($urandom_range(4, 12)));
    end
    if (replay_ok()) send_read(ID_RESPONSE);
    else send_read(ID_STATUS);
  endtask

  initial begin
    int wait_cycles;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.req_type = RT_HOST_BYTE;
    in_chan.report_id = 8'h00;
    in_chan.data_byte = 8'h00;
    in_chan.byte_index = 6'd0;
    in_chan.last_byte = 1'b0;
    txn_count = 0;
    replay_count = 0;
    replay_ptr = 0;
    slot_done = '0;
    send_idle_pct = 6;
    recv_stall_pct = 69;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corner transactions
    send_item(2'd3, 8'hff, 8'hff, 6'd63, 1'b1);
    send_item(RT_HOST_READ, ID_STATUS, 8'h00, 6'd0, 1'b0);
    send_item(RT_HOST_READ, 8'h00, 8'h00, 6'd0, 1'b0);
    send_item(RT_HOST_READ, 8'hff, 8'hff, 6'd63, 1'b1);
    send_item(RT_HOST_BYTE, 8'h00, 8'hff, 6'd0, 1'b1);
    send_item(RT_HOST_BYTE, 8'h00, 8'h00, 6'd63, 1'b1);
    send_item(RT_CTRL_BYTE, 8'h00, 8'h00, 6'd0, 1'b0);
    send_item(RT_CTRL_BYTE, 8'h00, 8'h77, 6'd1, 1'b0);
    send_item(RT_CTRL_BYTE, 8'h00, ID_RESPONSE, 6'd1, 1'b0);
    send_item(RT_CTRL_BYTE, 8'h00, 8'hff, 6'd63, 1'b1);
    send_item(RT_HOST_BYTE, 8'h00, 8'h5a, 6'd0, 1'b0);
    send_item(RT_CTRL_BYTE, 8'h00, 8'h00, 6'd0, 1'b0);
    send_item(RT_HOST_BYTE, 8'h00, CHAL_START, 6'd2, 1'b1);
    send_item(RT_HOST_BYTE, 8'h00, 8'h11, 6'd5, 1'b0);
    send_item(RT_HOST_BYTE, 8'h00, 8'h22, 6'd6, 1'b1);
    send_item(RT_HOST_READ, ID_STATUS, 8'h00, 6'd0, 1'b0);
    send_item(RT_CTRL_BYTE, 8'h00, 8'h00, 6'd0, 1'b0);
    send_item(RT_CTRL_BYTE, 8'h00, ID_STATUS, 6'd1, 1'b0);
    send_item(RT_HOST_BYTE, 8'h00, 8'h33, 6'd1, 1'b0);
    send_item(RT_CTRL_BYTE, 8'h00, 8'hff, 6'd3, 1'b0);
    send_item(RT_CTRL_BYTE, 8'h00, ID_STATUS, 6'd1, 1'b0);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 6 : (p == 1) ? 69 : 0;
      recv_stall_pct = (p == 0) ? 69 : (p == 1) ? 6 : 0;
      run_round();
      for (int i = 0; i < 10; i++) send_noise();
    end
    in_chan.valid <= 1'b0;

    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);

    $display("Run covered %0d input transactions, %0d response replay reads,",
             txn_count, replay_count);
    $display("status exchange, response collection and noise under three stall profiles.");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d, results still expected: %0d", mismatch_count, outstanding);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
